// File: src/porc_pkg.sv
`timescale 1ns / 1ps

package porc_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int KEY_WIDTH     = 64;
    localparam int COUNT_WIDTH   = 16;

    localparam int IN_KEY_W  = 64;
    localparam int OCC_W     = 16;
    localparam int SLOT_W    = $clog2(TABLE_ENTRIES);
    localparam int USED_W    = $clog2(TABLE_ENTRIES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_NULL = 1'b1;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic                 op;
        logic                 row_end;
    } t_item;

endpackage

// File: src/porc_stream_if.sv
`timescale 1ns / 1ps

interface porc_elem_if;
    logic                           valid;
    logic                           ready;
    logic [porc_pkg::IN_KEY_W-1:0]  elem_key;
    logic                           elem_is_null;
    logic                           row_end;

    modport source (output valid, output elem_key, output elem_is_null, output row_end,
                    input ready);
    modport sink   (input valid, input elem_key, input elem_is_null, input row_end,
                    output ready);
endinterface

interface porc_result_if;
    logic                        valid;
    logic                        ready;
    logic [porc_pkg::OCC_W-1:0]  occurrence;
    logic                        table_full;
    logic                        row_done;

    modport source (output valid, output occurrence, output table_full, output row_done,
                    input ready);
    modport sink   (input valid, input occurrence, input table_full, input row_done,
                    output ready);
endinterface

// File: src/porc_front.sv
`timescale 1ns / 1ps

module porc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    porc_elem_if.sink           i_elem,
    output logic                o_item_valid,
    output porc_pkg::t_item     o_item,
    input  logic                i_item_pop
);

    porc_pkg::t_item                r_q [porc_pkg::QUEUE_DEPTH];
    logic [porc_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [porc_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [porc_pkg::QCNT_W-1:0]    r_cnt;
    logic [porc_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [porc_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic [porc_pkg::QCNT_W-1:0]    n_cnt;
    porc_pkg::t_item                w_class;
    logic                           w_push;
    logic                           w_pop;

    // classify: mask key, tag null beats
    always_comb begin
        w_class.key     = i_elem.elem_key[porc_pkg::KEY_WIDTH-1:0];
        w_class.op      = i_elem.elem_is_null ? porc_pkg::OP_NULL : porc_pkg::OP_KEY;
        w_class.row_end = i_elem.row_end;
    end

    assign i_elem.ready = (r_cnt != porc_pkg::QCNT_W'(porc_pkg::QUEUE_DEPTH));
    assign w_push       = i_elem.valid && i_elem.ready;
    assign o_item_valid = (r_cnt != '0);
    assign w_pop        = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == porc_pkg::QPTR_W'(porc_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == porc_pkg::QPTR_W'(porc_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_class;
        end
    end

endmodule

// File: src/porc_back.sv
`timescale 1ns / 1ps

module porc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  porc_pkg::t_item     i_item,
    output logic                o_item_pop,
    porc_result_if.source       o_res
);

    localparam logic [porc_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [porc_pkg::KEY_WIDTH-1:0]     r_key   [porc_pkg::TABLE_ENTRIES];
    logic [porc_pkg::COUNT_WIDTH-1:0]   r_count [porc_pkg::TABLE_ENTRIES];
    logic [porc_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic [porc_pkg::USED_W-1:0]        r_used;
    logic [porc_pkg::COUNT_WIDTH-1:0]   r_null;

    logic                               r_out_valid;
    logic [porc_pkg::OCC_W-1:0]         r_occ;
    logic                               r_full;
    logic                               r_done;

    logic [porc_pkg::TABLE_ENTRIES-1:0] w_hit;
    logic                               w_any_hit;
    logic [porc_pkg::COUNT_WIDTH-1:0]   w_hit_count;
    logic [porc_pkg::COUNT_WIDTH-1:0]   w_hit_bump;
    logic [porc_pkg::COUNT_WIDTH-1:0]   w_null_bump;
    logic                               w_is_full;
    logic [porc_pkg::SLOT_W-1:0]        w_slot;
    logic                               w_go;
    logic                               w_insert;
    logic [porc_pkg::COUNT_WIDTH-1:0]   w_occ_cnt;
    logic                               w_full_flag;
    logic [porc_pkg::COUNT_WIDTH+porc_pkg::OCC_W-1:0] w_occ_ext;

    function automatic logic [porc_pkg::COUNT_WIDTH-1:0] bump(
        input logic [porc_pkg::COUNT_WIDTH-1:0] c
    );
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    always_comb begin
        w_hit_count = '0;
        for (int i = 0; i < porc_pkg::TABLE_ENTRIES; i++) begin
            w_hit[i] = r_valid[i] && (r_key[i] == i_item.key);
            if (w_hit[i]) begin
                w_hit_count = w_hit_count | r_count[i];
            end
        end
    end

    assign w_any_hit   = |w_hit;
    assign w_hit_bump  = bump(w_hit_count);
    assign w_null_bump = bump(r_null);
    assign w_is_full   = (r_used == porc_pkg::USED_W'(porc_pkg::TABLE_ENTRIES));
    assign w_slot      = r_used[porc_pkg::SLOT_W-1:0];

    assign w_go       = i_item_valid && (!r_out_valid || o_res.ready);
    assign o_item_pop = w_go;
    assign w_insert   = (i_item.op == porc_pkg::OP_KEY) && !w_any_hit && !w_is_full;

    always_comb begin
        w_full_flag = 1'b0;
        if (i_item.op == porc_pkg::OP_NULL) begin
            w_occ_cnt = w_null_bump;
        end else if (w_any_hit) begin
            w_occ_cnt = w_hit_bump;
        end else if (!w_is_full) begin
            w_occ_cnt = porc_pkg::COUNT_WIDTH'(1);
        end else begin
            w_occ_cnt   = '0;
            w_full_flag = 1'b1;
        end
    end

    assign w_occ_ext = {{porc_pkg::OCC_W{1'b0}}, w_occ_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_used      <= '0;
            r_null      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_go) begin
                // clear row after its last beat
                if (i_item.row_end) begin
                    r_valid <= '0;
                    r_used  <= '0;
                    r_null  <= '0;
                end else begin
                    if (i_item.op == porc_pkg::OP_NULL) begin
                        r_null <= w_null_bump;
                    end
                    if (w_insert) begin
                        r_valid[w_slot] <= 1'b1;
                        r_used          <= r_used + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_occ  <= w_occ_ext[porc_pkg::OCC_W-1:0];
            r_full <= w_full_flag;
            r_done <= i_item.row_end;
            for (int i = 0; i < porc_pkg::TABLE_ENTRIES; i++) begin
                if (i_item.op == porc_pkg::OP_KEY && w_hit[i]) begin
                    r_count[i] <= w_hit_bump;
                end else if (w_insert && (w_slot == porc_pkg::SLOT_W'(i))) begin
                    r_key[i]   <= i_item.key;
                    r_count[i] <= porc_pkg::COUNT_WIDTH'(1);
                end
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.occurrence = r_occ;
    assign o_res.table_full = r_full;
    assign o_res.row_done   = r_done;

endmodule

// File: src/per_row_occurrence_counter.sv
`timescale 1ns / 1ps
// A result is registered in the output stage after its element beat passes through
// the two-entry queue and the table stage; a busy output can hold it in the queue.
// Throughput: one element per cycle while results are taken, set by the parallel key
// compare and count update in the table stage; a two-entry queue decouples intake.
// Reset: synchronous, active low; clears the queue, the output valid flag, all entry
// valid bits, the entry count and the null count. Key and count storage are not reset.

module per_row_occurrence_counter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    porc_elem_if.sink       i_elem,
    porc_result_if.source   o_res
);

    logic               w_item_valid;
    porc_pkg::t_item    w_item;
    logic               w_item_pop;

    porc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem       (i_elem),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    porc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_res        (o_res)
    );

endmodule
